@@ rtl/encs_pkg.sv @@
package encs_pkg;

  // width of values, coordinates, centre and radius
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CFG_ADDR_WIDTH = 5;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_CENTER_X = 3'd0;
  localparam reg_idx_t REG_CENTER_Y = 3'd1;
  localparam reg_idx_t REG_CENTER_Z = 3'd2;
  localparam reg_idx_t REG_RADIUS   = 3'd3;
  localparam reg_idx_t REG_STRETCH  = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // |a - b| of two signed values, always fits the unsigned width
  function automatic logic [VALUE_WIDTH-1:0] abs_diff(
    input logic [VALUE_WIDTH-1:0] a,
    input logic [VALUE_WIDTH-1:0] b
  );
    logic signed [VALUE_WIDTH:0] d;
    d = $signed({a[VALUE_WIDTH-1], a}) - $signed({b[VALUE_WIDTH-1], b});
    return d[VALUE_WIDTH] ? VALUE_WIDTH'(-d) : d[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] abs_val(input logic [VALUE_WIDTH-1:0] a);
    return a[VALUE_WIDTH-1] ? VALUE_WIDTH'(-a) : a;
  endfunction

endpackage

@@ rtl/error_norms_curvilinear_sphere_cut.sv @@
// Weighted L2 and max error norms over a curvilinear grid with a spherical
// exclusion zone. One grid point is one transaction on the s_axis channel;
// tlast marks the final point of the final component. Points whose squared
// distance from the centre does not exceed the signed squared radius are
// skipped (a negative radius counts all points).
// The transaction marked last produces one result on m_axis: max error,
// saturating weighted square sum and max exact value; running state clears.
// The eight products of a point go through one shared 32x32 multiplier, one
// per cycle. With use_stretching set, a point that needs the division has its
// term divided by the stretching product in a restoring divider at one
// quotient bit per cycle. The block takes no new point until the current one
// is through. The result sits in an output register; while the receiver
// stalls, points are still taken and only a following last point waits
// until the pending result is taken.
// Reset clears the running values and the output valid, and sets the
// registers to their defaults (radius -1.0, stretching off). Configuration is
// through the APB port at byte addresses 0x00..0x10; pready is always high.
module error_norms_curvilinear_sphere_cut import encs_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // computed_value, exact_value, coord_x, coord_y, coord_z, cell_weight,
  // stretch_i, stretch_j (32 bits each, from the lowest bit up)
  input  logic [255:0]              s_axis_tdata,
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // max_error (32), weighted_square_sum (64), max_exact (32)
  output logic [127:0]              m_axis_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned VW = VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  // multiplier schedule; each step issues one product and consumes the previous
  localparam logic [3:0] STEP_DX  = 4'd0;
  localparam logic [3:0] STEP_DY  = 4'd1;
  localparam logic [3:0] STEP_DZ  = 4'd2;
  localparam logic [3:0] STEP_R   = 4'd3;
  localparam logic [3:0] STEP_ERR = 4'd4;
  localparam logic [3:0] STEP_WLO = 4'd5;
  localparam logic [3:0] STEP_WHI = 4'd6;
  localparam logic [3:0] STEP_DEN = 4'd7;
  localparam logic [3:0] STEP_END = 4'd8;

  state_t      state;
  logic [3:0]  step;

  logic [VW-1:0] center_x;
  logic [VW-1:0] center_y;
  logic [VW-1:0] center_z;
  logic [VW-1:0] sphere_radius;
  logic          use_stretching;

  // captured point
  logic [VW-1:0] err;
  logic [VW-1:0] ex;
  logic [VW-1:0] dx;
  logic [VW-1:0] dy;
  logic [VW-1:0] dz;
  logic [VW-1:0] rad;
  logic          neg_rad;
  logic [31:0]   weight;
  logic [31:0]   si;
  logic [31:0]   sj;
  logic          last_q;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [65:0]   dist_sq;
  logic [31:0]   e2hi;
  logic [95:0]   acc;
  logic          counted;
  logic [63:0]   term;

  logic [31:0]   run_err;
  logic [63:0]   run_sum;
  logic [31:0]   run_exact;

  logic [31:0]   out_err;
  logic [63:0]   out_sum;
  logic [31:0]   out_exact;
  logic          out_valid;

  logic          s_accept;
  logic          out_free;
  logic          upd_fire;
  logic [127:0]  acc_sh;
  logic          plain_sat;
  logic          div_go;
  logic [64:0]   sum_add;
  logic [31:0]   err_new;
  logic [31:0]   exact_new;
  logic [63:0]   sum_new;
  logic          cfg_we;
  reg_idx_t      cfg_idx;

  logic [63:0]   quotient;
  div_stat_t     div_stat;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !out_valid || m_axis_tready;
  assign upd_fire      = (state == S_UPD) && (!last_q || out_free);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_exact, out_sum, out_err};

  always_comb begin
    case (step)
      STEP_DX:  begin mul_a = dx;         mul_b = dx;     end
      STEP_DY:  begin mul_a = dy;         mul_b = dy;     end
      STEP_DZ:  begin mul_a = dz;         mul_b = dz;     end
      STEP_R:   begin mul_a = rad;        mul_b = rad;    end
      STEP_ERR: begin mul_a = err;        mul_b = err;    end
      STEP_WLO: begin mul_a = prod[31:0]; mul_b = weight; end
      STEP_WHI: begin mul_a = e2hi;       mul_b = weight; end
      STEP_DEN: begin mul_a = si;         mul_b = sj;     end
      default:  begin mul_a = '0;         mul_b = '0;     end
    endcase
  end

  // weight * err^2 has 3F fraction bits; stretched numerator is that shifted up by F
  always_comb begin
    acc_sh    = {32'b0, acc} << FRACTION_BITS;
    plain_sat = (acc >> (64 + FRACTION_BITS)) != '0;
    div_go    = use_stretching && (prod != '0) && (acc_sh[127:64] < prod);
  end

  always_comb begin
    sum_add   = {1'b0, run_sum} + {1'b0, term};
    err_new   = (counted && (err > run_err)) ? err : run_err;
    exact_new = (counted && (ex > run_exact)) ? ex : run_exact;
    if (!counted) begin
      sum_new = run_sum;
    end else begin
      sum_new = sum_add[64] ? '1 : sum_add[63:0];
    end
  end

  encs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_MUL) && (step == STEP_END) && div_go),
    .num_hi   (acc_sh[127:64]),
    .num_lo   (acc_sh[63:0]),
    .den      (prod),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (s_accept) begin
      err     <= abs_diff(s_axis_tdata[31:0], s_axis_tdata[63:32]);
      ex      <= abs_val(s_axis_tdata[63:32]);
      dx      <= abs_diff(s_axis_tdata[95:64], center_x);
      dy      <= abs_diff(s_axis_tdata[127:96], center_y);
      dz      <= abs_diff(s_axis_tdata[159:128], center_z);
      rad     <= abs_val(sphere_radius);
      neg_rad <= sphere_radius[VW-1];
      weight  <= s_axis_tdata[191:160];
      si      <= s_axis_tdata[223:192];
      sj      <= s_axis_tdata[255:224];
      last_q  <= s_axis_tlast;
    end
    if (state == S_MUL) begin
      prod <= {32'b0, mul_a} * {32'b0, mul_b};
      case (step) inside
        STEP_DY:         dist_sq <= {2'b00, prod};
        STEP_DZ, STEP_R: dist_sq <= dist_sq + {2'b00, prod};
        STEP_ERR:        counted <= neg_rad || (dist_sq > {2'b00, prod});
        STEP_WLO:        e2hi <= prod[63:32];
        STEP_WHI:        acc <= {32'b0, prod};
        STEP_DEN:        acc <= acc + {prod, 32'b0};
        STEP_END: begin
          if (!use_stretching) begin
            term <= plain_sat ? '1 : acc[63+FRACTION_BITS -: 64];
          end else begin
            // zero divisor or quotient beyond 64 bits saturates
            term <= '1;
          end
        end
        default: ;
      endcase
    end
    if ((state == S_DIV) && div_stat.done) begin
      term <= quotient;
    end
    if (upd_fire && last_q) begin
      out_err   <= err_new;
      out_sum   <= sum_new;
      out_exact <= exact_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      run_err   <= '0;
      run_sum   <= '0;
      run_exact <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !(upd_fire && last_q)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= S_MUL;
            step  <= STEP_DX;
          end
        end
        S_MUL: begin
          if (step == STEP_END) begin
            state <= div_go ? S_DIV : S_UPD;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_fire) begin
            state <= S_IDLE;
            if (last_q) begin
              run_err   <= '0;
              run_sum   <= '0;
              run_exact <= '0;
              out_valid <= 1'b1;
            end else begin
              run_err   <= err_new;
              run_sum   <= sum_new;
              run_exact <= exact_new;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      sphere_radius  <= VW'(-(64'sd1 <<< FRACTION_BITS));
      use_stretching <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CENTER_X: center_x       <= pwdata[VW-1:0];
        REG_CENTER_Y: center_y       <= pwdata[VW-1:0];
        REG_CENTER_Z: center_z       <= pwdata[VW-1:0];
        REG_RADIUS:   sphere_radius  <= pwdata[VW-1:0];
        REG_STRETCH:  use_stretching <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_CENTER_Z: prdata = center_z;
      REG_RADIUS:   prdata = sphere_radius;
      REG_STRETCH:  prdata = {31'b0, use_stretching};
      default:      prdata = '0;
    endcase
  end

endmodule

@@ rtl/encs_div.sv @@
module encs_div import encs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num_hi,
  input  logic [63:0] num_lo,
  input  logic [63:0] den,
  output logic [63:0] quotient,
  output div_stat_t   stat
);

  // restoring divider, one quotient bit per cycle; num_hi < den on start
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dreg;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] rem_sh;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem, quo[63]};
    diff   = {1'b0, rem_sh} - {2'b00, dreg};
    ge     = !diff[65];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num_hi;
      quo  <= num_lo;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : rem_sh[63:0];
      quo <= {quo[62:0], ge};
    end
  end

  assign quotient = quo;
  assign stat     = '{busy: busy, done: done};

endmodule

@@ rtl/encs_checker.sv @@
module encs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      s_axis_tlast,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [127:0]              m_axis_tdata
);

  // after reset the block is empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

  // one point at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accepting a point");

  // only a last point can produce a result
  a_no_result_without_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result without a last point");

  // |exact| of a signed value never exceeds 2^31
  a_max_exact_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[127:96] <= 32'h8000_0000)
    else $error("max_exact out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind error_norms_curvilinear_sphere_cut encs_checker u_encs_checker (.*);

@@ tb/norm_checker.sv @@
`timescale 1ns / 1ps

module norm_checker import encs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  // computed_value, exact_value, coord_x, coord_y, coord_z, cell_weight,
  // stretch_i, stretch_j (32 bits each, from the lowest bit up)
  input  logic [255:0]              in_data,
  input  logic                      in_last,
  input  logic                      out_valid,
  input  logic                      out_ready,
  // max_error (32), weighted_square_sum (64), max_exact (32)
  input  logic [127:0]              out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]               pwdata,
  output int                        mismatches,
  output int                        pending,
  output int                        reports_checked
);

  localparam int FRAC = 16;
  localparam logic [63:0] SUM_MAX = '1;
  localparam logic [31:0] WORD_MAX = '1;

  // first member lands in the top bits
  typedef struct packed {
    logic [31:0] max_exact;
    logic [63:0] square_sum;
    logic [31:0] max_error;
  } norm_report_t;

  logic signed [31:0] ctr_x, ctr_y, ctr_z, radius;
  logic               stretch_on;
  logic [31:0]        run_max_err, run_max_exact;
  logic [63:0]        run_sum;
  norm_report_t       expected_reports[$];

  function automatic logic [32:0] abs_gap(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = a - b;
    return d < 0 ? -d : d;
  endfunction

  function automatic logic point_counted(input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z);
    logic [32:0] dx, dy, dz;
    logic [67:0] dist_sq;
    logic [31:0] r;
    logic [63:0] r2;
    if (radius < 0) return 1'b1;
    dx = abs_gap(x, ctr_x);
    dy = abs_gap(y, ctr_y);
    dz = abs_gap(z, ctr_z);
    dist_sq = 68'(dx) * dx + 68'(dy) * dy + 68'(dz) * dz;
    r = radius;
    r2 = 64'(r) * r;
    return dist_sq > 68'(r2);
  endfunction

  function automatic logic [63:0] weighted_term(input logic [32:0] err,
                                                input logic [31:0] w,
                                                input logic [31:0] si,
                                                input logic [31:0] sj);
    logic [127:0] prod, quot;
    logic [63:0]  den;
    prod = 128'(err) * err * w;
    if (stretch_on) begin
      den = 64'(si) * sj;
      if (den == 0 || prod[127:112] != 0) return SUM_MAX;
      quot = (prod << FRAC) / 128'(den);
      return quot[127:64] != 0 ? SUM_MAX : quot[63:0];
    end
    prod = prod >> FRAC;
    return prod[127:64] != 0 ? SUM_MAX : prod[63:0];
  endfunction

  task automatic absorb_point(input logic [255:0] d, input logic last_pt);
    logic signed [31:0] comp, exact;
    logic [32:0]        err;
    logic [31:0]        exact_mag, err_clip;
    logic [63:0]        term;
    norm_report_t       rpt;
    comp = d[31:0];
    exact = d[63:32];
    if (point_counted(d[95:64], d[127:96], d[159:128])) begin
      err = abs_gap(comp, exact);
      exact_mag = exact[31] ? -exact : exact;
      err_clip = err[32] ? WORD_MAX : err[31:0];
      term = weighted_term(err, d[191:160], d[223:192], d[255:224]);
      if (err_clip > run_max_err) run_max_err = err_clip;
      if (exact_mag > run_max_exact) run_max_exact = exact_mag;
      run_sum = (run_sum > SUM_MAX - term) ? SUM_MAX : run_sum + term;
    end
    if (last_pt) begin
      rpt.max_error = run_max_err;
      rpt.square_sum = run_sum;
      rpt.max_exact = run_max_exact;
      expected_reports.push_back(rpt);
      run_max_err = '0;
      run_sum = '0;
      run_max_exact = '0;
    end
  endtask

  task automatic check_report(input norm_report_t got);
    norm_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (got.max_error !== want.max_error) begin
      $display("%0t: max_error expected %h got %h", $time, want.max_error, got.max_error);
      mismatches++;
    end
    if (got.square_sum !== want.square_sum) begin
      $display("%0t: weighted_square_sum expected %h got %h", $time,
               want.square_sum, got.square_sum);
      mismatches++;
    end
    if (got.max_exact !== want.max_exact) begin
      $display("%0t: max_exact expected %h got %h", $time, want.max_exact, got.max_exact);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ctr_x = '0;
      ctr_y = '0;
      ctr_z = '0;
      radius = 32'hFFFF_0000;
      stretch_on = 1'b0;
      run_max_err = '0;
      run_sum = '0;
      run_max_exact = '0;
      expected_reports.delete();
      mismatches = 0;
      reports_checked = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) check_report(out_data);
      if (in_valid && in_ready) absorb_point(in_data, in_last);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:2]))
          REG_CENTER_X: ctr_x = pwdata;
          REG_CENTER_Y: ctr_y = pwdata;
          REG_CENTER_Z: ctr_z = pwdata;
          REG_RADIUS:   radius = pwdata;
          REG_STRETCH:  stretch_on = pwdata[0];
          default: ;
        endcase
      end
      pending <= expected_reports.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import encs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_PHASES = 6;
  localparam int POINTS_PER_PHASE = 185;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MIN_Q = 32'h8000_0000;
  localparam logic [31:0] MAX_Q = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam reg_idx_t REG_SPARE = 3'd7;

  typedef struct packed {
    logic [31:0] stretch_j;
    logic [31:0] stretch_i;
    logic [31:0] weight;
    logic [31:0] coord_z;
    logic [31:0] coord_y;
    logic [31:0] coord_x;
    logic [31:0] exact;
    logic [31:0] computed;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // computed_value, exact_value, coord_x, coord_y, coord_z, cell_weight,
  // stretch_i, stretch_j (32 bits each, from the lowest bit up)
  logic [255:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // max_error (32), weighted_square_sum (64), max_exact (32)
  logic [127:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic steady = 1'b0;
  logic [31:0] cfg_x = '0, cfg_y = '0, cfg_z = '0;
  int mismatches, pending, reports_checked;
  int points_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  error_norms_curvilinear_sphere_cut dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  norm_checker chk (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_data(s_axis_tdata),
    .in_last(s_axis_tlast),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .mismatches(mismatches),
    .pending(pending),
    .reports_checked(reports_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic point_t make_point(input logic [31:0] comp, input logic [31:0] exact,
                                        input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z, input logic [31:0] w,
                                        input logic [31:0] si, input logic [31:0] sj);
    point_t p;
    p.computed = comp;
    p.exact = exact;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    p.weight = w;
    p.stretch_i = si;
    p.stretch_j = sj;
    return p;
  endfunction

  // +-64.0 around zero
  function automatic logic [31:0] near_zero();
    return $urandom_range(0, 32'h007F_FFFF) - 32'h003F_FFFF;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? MIN_Q : MAX_Q;
      1: return $urandom_range(0, 1) ? 32'h0 : ALL_ONES;
      2, 3: return near_zero();
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] place(input logic [31:0] c);
    case ($urandom_range(0, 7))
      0: return c;
      1: return $urandom;
      2: return c + $urandom_range(0, 1) - 1;
      default: return c + near_zero();
    endcase
  endfunction

  function automatic logic [31:0] pick_scale(input logic nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom;
        return (nonzero && v == 0) ? 32'h1 : v;
      end
      1: return ONE;
      2: return $urandom_range(1, 32'h0004_0000);
      default: return nonzero ? ALL_ONES : 32'h0;
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.exact = pick_value();
    // mostly small errors so the sum does not always pin at its ceiling
    p.computed = ($urandom_range(0, 2) != 0) ?
                 p.exact + $urandom_range(0, 32'h0003_FFFF) - 32'h0001_FFFF : pick_value();
    p.coord_x = place(cfg_x);
    p.coord_y = place(cfg_y);
    p.coord_z = place(cfg_z);
    p.weight = pick_scale(1'b0);
    p.stretch_i = pick_scale(1'b1);
    p.stretch_j = pick_scale(1'b1);
    return p;
  endfunction

  task automatic send_point(input point_t p, input logic last_pt);
    while (!steady && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    s_axis_tlast <= last_pt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    points_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] r,
                              input logic stretch);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    write_reg(REG_STRETCH, {31'b0, stretch});
    cfg_x = cx;
    cfg_y = cy;
    cfg_z = cz;
    settings_applied++;
  endtask

  // all results in, then let any point still in the divider finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sent, len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: negative radius counts everything, no stretching
    send_point(make_point(0, 0, 0, 0, 0, 0, ONE, ONE), 1'b0);
    send_point(make_point(MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, ALL_ONES, ALL_ONES, ALL_ONES),
               1'b0);
    send_point(make_point(MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, ONE, 32'h1, 32'h1), 1'b0);
    send_point(make_point(MIN_Q, MIN_Q, 0, 0, 0, ONE, ONE, ONE), 1'b1);
    send_point(make_point(32'h0001_8000, ONE, 0, 0, 0, ONE, ONE, ONE), 1'b1);

    // zero radius with stretching; a write to an unmapped register must not stick
    wait_idle();
    write_reg(REG_SPARE, ALL_ONES);
    apply_config(ONE, 32'hFFFE_0000, 32'h0003_0000, 32'h0, 1'b1);
    send_point(make_point(MAX_Q, MIN_Q, ONE, 32'hFFFE_0000, 32'h0003_0000, ONE, ONE, ONE),
               1'b0);
    send_point(make_point(32'h0002_0000, ONE, ONE + 1, 32'hFFFE_0000, 32'h0003_0000,
                          ONE, ONE, ONE), 1'b0);
    send_point(make_point(32'h0003_0000, 0, 0, 0, 0, ONE, 32'h0, ONE), 1'b0);
    send_point(make_point(MIN_Q, MAX_Q, 0, 0, 0, ALL_ONES, ALL_ONES, ALL_ONES), 1'b1);
    // frame that ends on a point inside the sphere
    send_point(make_point(ONE, 0, ONE, 32'hFFFE_0000, 32'h0003_0000, ONE, ONE, ONE), 1'b1);

    // largest radius around the most negative corner
    wait_idle();
    apply_config(MIN_Q, MIN_Q, MIN_Q, MAX_Q, 1'b0);
    send_point(make_point(32'h0005_0000, 32'h0002_0000, MAX_Q, MAX_Q, MAX_Q, ONE, ONE, ONE),
               1'b0);
    send_point(make_point(MAX_Q, 0, MIN_Q, MIN_Q, MIN_Q, ALL_ONES, ONE, ONE), 1'b1);

    // most negative radius
    wait_idle();
    apply_config(0, 0, 0, MIN_Q, 1'b0);
    send_point(make_point(ONE, 0, MIN_Q, MAX_Q, 0, ONE, ONE, ONE), 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: apply_config(near_zero(), near_zero(), near_zero(),
                        $urandom_range(0, 32'h0020_0000), 1'b0);
        1: apply_config(near_zero(), near_zero(), near_zero(),
                        $urandom_range(0, 32'h0020_0000), 1'b1);
        2: apply_config(MAX_Q, MIN_Q, 0, MAX_Q, 1'b1);
        3: apply_config($urandom, $urandom, $urandom, MIN_Q, 1'b0);
        4: apply_config(0, 0, 0, 0, 1'b1);
        default: apply_config(near_zero(), near_zero(), near_zero(), $urandom, 1'b0);
      endcase
      // one phase with neither side ever pausing
      steady <= (ph == 2);
      sent = 0;
      while (sent < POINTS_PER_PHASE) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_point(random_point(), k == len - 1);
          sent++;
        end
      end
    end

    wait_idle();
    $display("covered %0d grid points over %0d register settings", points_sent,
             settings_applied);
    $display("compared %0d norm results, %0d mismatches", reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
